/* hdl/krt_pkg.sv */
// Package for the keyed record table: item, result and record types,
// op and status codes, controller states and controller/datapath signal groups.
// No dependencies.
package krt_pkg;

  // Table depth default and the most results one list may give
  localparam int MAX_RECORDS_DEF = 32;
  localparam int RESULT_LIMIT    = 32;

  typedef enum logic [1:0] {
    OP_UPSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_APPENDED   = 3'd1,
    ST_FULL       = 3'd2,
    ST_REMOVED    = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_LIST_REC   = 3'd5,
    ST_LIST_EMPTY = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] record_key;
    logic [15:0] record_flags;
    logic [15:0] record_size;
    logic [7:0]  list_limit;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_key;
    logic [15:0] out_flags;
    logic [15:0] out_size;
    logic [5:0]  record_count;
    logic        last;
  } result_t;

  // One table entry as held in the record memory
  typedef struct packed {
    logic [15:0] key;
    logic [15:0] flags;
    logic [15:0] size;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST,
    S_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;         // capture the accepted item
    logic    scan_start;   // start a key search over the table
    logic    list_start;   // start a list walk
    logic    shift_start;  // start moving records down past the hit
    logic    step;         // advance the read pointer
    logic    upd_wr;       // overwrite the hit entry
    logic    app_wr;       // append at the end and bump the count
    logic    shift_wr;     // write back the record read last cycle one place lower
    logic    dec;          // drop the count by one
    logic    emit;         // send an op result
    logic    list_emit;    // send the record read last cycle as a list result
    status_t emit_status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;       // the entry read last cycle carries the key
    logic drained;   // pointer at its limit and nothing in flight
    logic room;      // table not full
    logic lim_zero;  // walk limit is zero
  } dp_stat_t;

endpackage

/* hdl/krt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module krt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/krt_dp.sv */
// Datapath of the keyed record table: record memory, walk pointer, held count,
// item capture and result register. Depends on krt_pkg and krt_ram.
module krt_dp
  import krt_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  item_t    item,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     result_valid,
  output result_t  result
);

  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [CW-1:0] pidx;
  logic [CW-1:0] lim;
  logic          pv;
  logic [15:0]   key_reg;
  logic [15:0]   flags_reg;
  logic [15:0]   size_reg;

  logic          we;
  logic [CW-1:0] widx;
  rec_t          wdata;
  rec_t          rdata;
  logic [CW-1:0] pidx_dn;
  logic [7:0]    count8;
  logic [7:0]    n_cnt;
  logic [7:0]    n_list;
  logic          more;

  krt_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(MAX_RECORDS)
  ) u_rec_ram (
    .clk  (clk),
    .we   (we),
    .waddr(widx[AW-1:0]),
    .wdata(wdata),
    .raddr(ptr[AW-1:0]),
    .rdata(rdata)
  );

  // Status back to the controller
  assign more          = (ptr < lim);
  assign stat.hit      = pv && (rdata.key == key_reg);
  assign stat.drained  = !pv && !more;
  assign stat.room     = (count < CW'(MAX_RECORDS));
  assign stat.lim_zero = (lim == '0);

  // List length: held count, capped by the item's limit and the result limit
  assign count8 = 8'(count);
  assign n_cnt  = (count8 < item.list_limit) ? count8 : item.list_limit;
  assign n_list = (n_cnt > 8'(RESULT_LIMIT)) ? 8'(RESULT_LIMIT) : n_cnt;

  // Pick the write address and data
  assign pidx_dn = pidx - 1'b1;
  always_comb begin
    we    = 1'b0;
    widx  = pidx;
    wdata = '{key: key_reg, flags: flags_reg, size: size_reg};
    if (cmd.upd_wr) begin
      we = 1'b1;
    end else if (cmd.app_wr) begin
      we   = 1'b1;
      widx = count;
    end else if (cmd.shift_wr && pv) begin
      we    = 1'b1;
      widx  = pidx_dn;
      wdata = rdata;
    end
  end

  // Walk pointer, read pipeline flag and held count
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      pidx  <= '0;
      lim   <= '0;
      pv    <= 1'b0;
      count <= '0;
    end else begin
      if (cmd.scan_start) begin
        ptr <= '0;
        pv  <= 1'b0;
        lim <= count;
      end else if (cmd.list_start) begin
        ptr <= '0;
        pv  <= 1'b0;
        lim <= CW'(n_list);
      end else if (cmd.shift_start) begin
        ptr <= pidx + 1'b1;
        pv  <= 1'b0;
      end else if (cmd.step) begin
        pv <= more;
        if (more) begin
          pidx <= ptr;
          ptr  <= ptr + 1'b1;
        end
      end
      if (cmd.app_wr) begin
        count <= count + 1'b1;
      end else if (cmd.dec) begin
        count <= count - 1'b1;
      end
    end
  end

  // Hold the accepted item's fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_reg   <= item.record_key;
      flags_reg <= item.record_flags;
      size_reg  <= item.record_size;
    end
  end

  // Result register: one strobe per result
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit || (cmd.list_emit && pv);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status       <= cmd.emit_status;
      result.out_key      <= (cmd.emit_status == ST_LIST_EMPTY) ? 16'd0 : key_reg;
      result.out_flags    <= 16'd0;
      result.out_size     <= 16'd0;
      result.record_count <= 6'(count);
      result.last         <= 1'b1;
    end else if (cmd.list_emit && pv) begin
      result.status       <= ST_LIST_REC;
      result.out_key      <= rdata.key;
      result.out_flags    <= rdata.flags;
      result.out_size     <= rdata.size;
      result.record_count <= 6'(count);
      result.last         <= (CW'(pidx + 1'b1) == lim);
    end
  end

  // Count stays within the table depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RECORDS))
    else $error("held count beyond table depth");

  // Append only into a table with room
  a_app_room: assert property (@(posedge clk) disable iff (rst)
    cmd.app_wr |-> stat.room)
    else $error("append into a full table");

  // A shift write never targets below entry zero
  a_shift_idx: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_wr && pv) |-> (pidx != '0))
    else $error("shift write below entry zero");

endmodule

/* hdl/krt_ctrl.sv */
// Controller of the keyed record table: sequences search, update, append,
// shift-down and list walks. Depends on krt_pkg.
module krt_ctrl
  import krt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic [1:0] op,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd
);

  state_t     state;
  state_t     state_next;
  logic [1:0] op_reg;
  logic [1:0] op_reg_next;
  status_t    rsp;
  status_t    rsp_next;

  assign busy = (state != S_IDLE);

  // State and held op/status
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op_reg <= OP_UPSERT;
      rsp    <= ST_UPDATED;
    end else begin
      state  <= state_next;
      op_reg <= op_reg_next;
      rsp    <= rsp_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next      = state;
    op_reg_next     = op_reg;
    rsp_next        = rsp;
    cmd             = '0;
    cmd.emit_status = rsp;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          op_reg_next = op;
          case (op)
            OP_UPSERT, OP_REMOVE: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            OP_LIST: begin
              cmd.list_start = 1'b1;
              state_next     = S_LIST;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          if (op_reg == OP_UPSERT) begin
            cmd.upd_wr = 1'b1;
            rsp_next   = ST_UPDATED;
            state_next = S_RESP;
          end else begin
            cmd.shift_start = 1'b1;
            state_next      = S_SHIFT;
          end
        end else if (stat.drained) begin
          state_next = S_RESP;
          if (op_reg == OP_UPSERT) begin
            if (stat.room) begin
              cmd.app_wr = 1'b1;
              rsp_next   = ST_APPENDED;
            end else begin
              rsp_next = ST_FULL;
            end
          end else begin
            rsp_next = ST_NOT_FOUND;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.step     = 1'b1;
        cmd.shift_wr = 1'b1;
        if (stat.drained) begin
          cmd.dec    = 1'b1;
          rsp_next   = ST_REMOVED;
          state_next = S_RESP;
        end
      end
      S_LIST: begin
        cmd.step      = 1'b1;
        cmd.list_emit = 1'b1;
        if (stat.drained) begin
          if (stat.lim_zero) begin
            rsp_next   = ST_LIST_EMPTY;
            state_next = S_RESP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_RESP: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The response state lasts one cycle
  a_resp_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |=> (state == S_IDLE))
    else $error("response state held");

  // Stepping never coincides with a walk start
  a_step_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !(cmd.scan_start || cmd.list_start || cmd.shift_start))
    else $error("step during walk start");

  // Writes to the table are never doubled up
  a_wr_excl: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.upd_wr, cmd.app_wr, cmd.shift_wr}) <= 1)
    else $error("conflicting table writes");

endmodule

/* hdl/keyed_record_table_upsert_core.sv */
// Top level of the keyed record table: controller plus datapath.
// Depends on krt_pkg, krt_ctrl, krt_dp (and krt_ram through krt_dp).
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------
//  item in  | start high while busy low   | item   (item_t)
//  result   | result_valid, one cycle     | result (result_t)
//
// Upsert: the scan reads entries in turn; a hit overwrites that entry, a miss
// appends at the end, or reports full when there is no room. Remove: a hit moves
// the later records down one place and drops the count; a miss reports not found.
// List: one result per cycle, capped by count, item limit and RESULT_LIMIT; an
// empty list gives one. The record memory's single read port reads one entry a cycle.
// Reset clears the held count to an empty table; no memory clear pass.
// The receiver cannot stall results; busy alone holds items off.
module keyed_record_table_upsert_core
  import krt_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    result_valid,
  output result_t result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  krt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (item.op),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  krt_dp #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule
